/* src/assert_macros.svh */
// Assertion macros used by the checker file mshc_checker.sv.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define MSHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define MSHC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mshc_pkg.sv */
// Package for the multiply-shift hash collision checker.
// Widths, reset values, outcome codes and state types; no dependencies.
package mshc_pkg;

  localparam int unsigned MAX_INDEX_BITS_DEF = 12;
  localparam int unsigned WORD_W             = 64;
  localparam int unsigned STAMP_W            = 32;
  localparam int unsigned SLOT_W             = 12;
  localparam int unsigned WIDTH_W            = 4;
  localparam int unsigned COUNT_W            = 13;
  localparam int unsigned COUNT_MAX          = 4096;
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 4'd12;
  localparam logic [STAMP_W-1:0] EPOCH_RESET = 32'd1;

  typedef enum logic [1:0] {
    OUT_STORED   = 2'd0,
    OUT_MATCHED  = 2'd1,
    OUT_CONFLICT = 2'd2,
    OUT_SKIPPED  = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL0,
    F_MUL1,
    F_MUL2,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_LOOK
  } back_state_t;

endpackage

/* src/mshc_if.sv */
// Valid/ready channel interfaces for the collision checker.
// Depends on mshc_pkg for field widths and the outcome type.
interface mshc_in_if import mshc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               start_trial;
  logic [WORD_W-1:0]  multiplier;
  logic [WIDTH_W-1:0] index_width;
  logic [WORD_W-1:0]  key;
  logic [WORD_W-1:0]  ref_value;

  modport source (output valid, start_trial, multiplier, index_width, key, ref_value,
                  input ready);
  modport sink   (input valid, start_trial, multiplier, index_width, key, ref_value,
                  output ready);
endinterface

interface mshc_out_if import mshc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  slot;
  outcome_t           outcome;
  logic               trial_ok;
  logic [COUNT_W-1:0] accepted_count;

  modport source (output valid, slot, outcome, trial_ok, accepted_count, input ready);
  modport sink   (input valid, slot, outcome, trial_ok, accepted_count, output ready);
endinterface

/* src/mshc_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mshc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/mshc_queue.sv */
// Small register FIFO between the hashing front end and the table back end.
// No dependencies.
module mshc_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         valid
);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* src/mshc_front.sv */
// Front end: takes input transfers, latches trial parameters, hashes the key.
// Depends on mshc_pkg and mshc_in_if; feeds mshc_queue.
module mshc_front import mshc_pkg::*; #(
  parameter int unsigned MAX_INDEX_BITS = MAX_INDEX_BITS_DEF,
  localparam int unsigned QW = 1 + MAX_INDEX_BITS + WORD_W
) (
  input  logic          clk,
  input  logic          rst_n,
  mshc_in_if.sink       in_ch,
  input  logic          clearing,
  input  logic          q_full,
  output logic          q_push,
  output logic [QW-1:0] q_wdata
);

  localparam int unsigned CW     = $clog2(MAX_INDEX_BITS + 1);
  localparam int unsigned CMP_W  = (CW > WIDTH_W) ? CW : WIDTH_W;
  localparam int unsigned HALF_W = WORD_W / 2;

  front_state_t state_r, state_nxt;

  logic [WORD_W-1:0]  held_mult_r;
  logic [WIDTH_W-1:0] held_width_r;
  logic [WORD_W-1:0]  key_r;
  logic [WORD_W-1:0]  val_r;
  logic               start_r;
  logic [WORD_W-1:0]  acc_r, acc_nxt;

  logic                      xfer;
  logic [HALF_W-1:0]         mul_a, mul_b;
  logic [WORD_W-1:0]         prod;
  logic [CMP_W-1:0]          w_ext;
  logic [CW-1:0]             w_eff;
  logic [CW-1:0]             sh;
  logic [MAX_INDEX_BITS-1:0] idx;

  assign xfer = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (xfer) state_nxt = F_MUL0;
      F_MUL0:  state_nxt = F_MUL1;
      F_MUL1:  state_nxt = F_MUL2;
      F_MUL2:  state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == F_IDLE) && !clearing;
    q_push      = (state_r == F_PUSH) && !q_full;
  end

  always_comb begin
    case (state_r)
      F_MUL1: begin
        mul_a = held_mult_r[HALF_W-1:0];
        mul_b = key_r[WORD_W-1:HALF_W];
      end
      F_MUL2: begin
        mul_a = held_mult_r[WORD_W-1:HALF_W];
        mul_b = key_r[HALF_W-1:0];
      end
      default: begin
        mul_a = held_mult_r[HALF_W-1:0];
        mul_b = key_r[HALF_W-1:0];
      end
    endcase
    prod = WORD_W'(mul_a) * WORD_W'(mul_b);
    case (state_r)
      F_MUL0:  acc_nxt = prod;
      F_MUL1,
      F_MUL2:  acc_nxt = {acc_r[WORD_W-1:HALF_W] + prod[HALF_W-1:0], acc_r[HALF_W-1:0]};
      default: acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    w_ext = CMP_W'(held_width_r);
    if (w_ext == '0) begin
      w_eff = CW'(1);
    end else if (w_ext > CMP_W'(MAX_INDEX_BITS)) begin
      w_eff = CW'(MAX_INDEX_BITS);
    end else begin
      w_eff = CW'(w_ext);
    end
    sh      = CW'(MAX_INDEX_BITS) - w_eff;
    idx     = acc_r[WORD_W-1 -: MAX_INDEX_BITS] >> sh;
    q_wdata = {start_r, idx, val_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_IDLE;
      held_mult_r  <= '0;
      held_width_r <= WIDTH_RESET;
    end else begin
      state_r <= state_nxt;
      if (xfer && in_ch.start_trial) begin
        held_mult_r  <= in_ch.multiplier;
        held_width_r <= in_ch.index_width;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (xfer) begin
      key_r   <= in_ch.key;
      val_r   <= in_ch.ref_value;
      start_r <= in_ch.start_trial;
    end
  end

endmodule

/* src/mshc_back.sv */
// Back end: stamp/value table lookup, collision decision, trial state, result register.
// Depends on mshc_pkg, mshc_out_if and mshc_ram; fed from mshc_queue.
module mshc_back import mshc_pkg::*; #(
  parameter int unsigned MAX_INDEX_BITS = MAX_INDEX_BITS_DEF,
  localparam int unsigned QW = 1 + MAX_INDEX_BITS + WORD_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  logic [QW-1:0] q_rdata,
  output logic          q_pop,
  output logic          clearing,
  mshc_out_if.source    out_ch
);

  localparam int unsigned DEPTH = 1 << MAX_INDEX_BITS;
  localparam int unsigned EXT_W = (MAX_INDEX_BITS > SLOT_W) ? MAX_INDEX_BITS : SLOT_W;

  back_state_t state_r, state_nxt;

  logic [MAX_INDEX_BITS-1:0] clr_r, clr_nxt;
  logic [STAMP_W-1:0]        epoch_r;
  logic                      failed_r;
  logic [COUNT_W-1:0]        count_r;

  logic                      start_r;
  logic [MAX_INDEX_BITS-1:0] idx_r;
  logic [WORD_W-1:0]         val_r;

  logic                      out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]         out_slot_r;
  outcome_t                  out_outcome_r;
  logic                      out_ok_r;
  logic [COUNT_W-1:0]        out_count_r;

  logic                      load;
  logic                      q_start;
  logic [MAX_INDEX_BITS-1:0] q_idx;
  logic [WORD_W-1:0]         q_val;
  logic [STAMP_W-1:0]        rd_stamp;
  logic [WORD_W-1:0]         rd_val;
  logic [STAMP_W-1:0]        ep;
  logic                      fl;
  logic [COUNT_W-1:0]        ac;
  outcome_t                  oc;
  logic                      fail_new;
  logic [COUNT_W-1:0]        count_new;
  logic [EXT_W-1:0]          idx_ext;
  logic                      stamp_we;
  logic [MAX_INDEX_BITS-1:0] stamp_waddr;
  logic [STAMP_W-1:0]        stamp_wdata;
  logic                      val_we;

  assign q_start = q_rdata[QW-1];
  assign q_idx   = q_rdata[WORD_W +: MAX_INDEX_BITS];
  assign q_val   = q_rdata[WORD_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLEAR: if (clr_r == '1) state_nxt = B_IDLE;
      B_IDLE:  if (q_valid) state_nxt = B_LOOK;
      B_LOOK:  if (load) state_nxt = B_IDLE;
      default: state_nxt = B_CLEAR;
    endcase
  end

  always_comb begin
    clearing = (state_r == B_CLEAR);
    q_pop    = (state_r == B_IDLE) && q_valid;
    load     = (state_r == B_LOOK) && (!out_valid_r || out_ch.ready);
  end

  always_comb begin
    ep = start_r ? epoch_r + STAMP_W'(1) : epoch_r;
    fl = start_r ? 1'b0 : failed_r;
    ac = start_r ? '0 : count_r;
    if (fl) begin
      oc = OUT_SKIPPED;
    end else if (rd_stamp != ep) begin
      oc = OUT_STORED;
    end else if (rd_val == val_r) begin
      oc = OUT_MATCHED;
    end else begin
      oc = OUT_CONFLICT;
    end
    fail_new  = fl || (oc == OUT_CONFLICT);
    count_new = ac;
    if (((oc == OUT_STORED) || (oc == OUT_MATCHED)) && (ac < COUNT_W'(COUNT_MAX))) begin
      count_new = ac + COUNT_W'(1);
    end
    idx_ext       = EXT_W'(idx_r);
    clr_nxt       = clearing ? clr_r + MAX_INDEX_BITS'(1) : clr_r;
    out_valid_nxt = load || (out_valid_r && !out_ch.ready);
    val_we        = load && (oc == OUT_STORED);
    stamp_we      = clearing || val_we;
    stamp_waddr   = clearing ? clr_r : idx_r;
    stamp_wdata   = clearing ? '0 : ep;
  end

  mshc_ram #(.WIDTH(STAMP_W), .DEPTH(DEPTH)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (stamp_wdata),
    .re    (q_pop),
    .raddr (q_idx),
    .rdata (rd_stamp)
  );

  mshc_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (idx_r),
    .wdata (val_r),
    .re    (q_pop),
    .raddr (q_idx),
    .rdata (rd_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      epoch_r     <= EPOCH_RESET;
      failed_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (load) begin
        epoch_r  <= ep;
        failed_r <= fail_new;
        count_r  <= count_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      start_r <= q_start;
      idx_r   <= q_idx;
      val_r   <= q_val;
    end
    if (load) begin
      out_slot_r    <= idx_ext[SLOT_W-1:0];
      out_outcome_r <= oc;
      out_ok_r      <= !fail_new;
      out_count_r   <= count_new;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.slot           = out_slot_r;
  assign out_ch.outcome        = out_outcome_r;
  assign out_ch.trial_ok       = out_ok_r;
  assign out_ch.accepted_count = out_count_r;

endmodule

/* src/multiply_shift_hash_collision_check.sv */
// Top level of the multiply-shift hash collision checker.
// Depends on mshc_pkg, mshc_if, mshc_front, mshc_queue and mshc_back.
//
// Streams key/value pairs against a candidate 64-bit multiplier: each key hashes to the
// top index_width bits (clamped to 1..MAX_INDEX_BITS) of the low 64-bit product, and the
// slot table (epoch stamps plus stored values, 2^MAX_INDEX_BITS entries each) flags any
// slot that would have to hold two different values. After reset the stamp memory is
// swept to zero, one entry a cycle, with in_ch.ready low. After that each item passes the
// front-end states F_IDLE (accept), F_MUL0, F_MUL1 and F_MUL2 (the three 32x32 partial
// products of the key hash sharing one multiplier) and F_PUSH (hand-off, held while the
// queue is full); a new item is taken only back in F_IDLE. The table back end does a
// registered read, then compare and write (held while a result waits on a stalled
// receiver), and runs behind a two-entry queue.
module multiply_shift_hash_collision_check import mshc_pkg::*; #(
  parameter int unsigned MAX_INDEX_BITS = MAX_INDEX_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mshc_in_if.sink    in_ch,
  mshc_out_if.source out_ch
);

  localparam int unsigned QW = 1 + MAX_INDEX_BITS + WORD_W;

  logic          clearing;
  logic          q_full;
  logic          q_push;
  logic [QW-1:0] q_wdata;
  logic          q_pop;
  logic [QW-1:0] q_rdata;
  logic          q_valid;

  mshc_front #(.MAX_INDEX_BITS(MAX_INDEX_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  mshc_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  mshc_back #(.MAX_INDEX_BITS(MAX_INDEX_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule

/* src/mshc_checker.sv */
// Port-level checker for the collision checker, bound to the top level.
// Depends on mshc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mshc_checker import mshc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SLOT_W-1:0]  out_slot,
  input logic [1:0]         out_outcome,
  input logic               out_trial_ok,
  input logic [COUNT_W-1:0] out_accepted_count
);

  logic       in_x;
  logic       out_x;
  logic [3:0] pend_r, pend_nxt;

  assign in_x  = in_valid && in_ready;
  assign out_x = out_valid && out_ready;

  always_comb begin
    case ({in_x, out_x})
      2'b10:   pend_nxt = pend_r + 4'd1;
      2'b01:   pend_nxt = pend_r - 4'd1;
      default: pend_nxt = pend_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `MSHC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_slot), "result dropped or changed while stalled")
  `MSHC_ASSERT_IMP(a_ok_vs_outcome, out_valid, out_trial_ok == ((out_outcome == OUT_STORED) || (out_outcome == OUT_MATCHED)), "trial_ok disagrees with outcome")
  `MSHC_ASSERT_IMP(a_count_sat, out_valid, out_accepted_count <= COUNT_W'(COUNT_MAX), "accepted count beyond saturation")
  `MSHC_ASSERT_IMP(a_no_invented, out_valid, pend_r != 4'd0, "result without a pending input transfer")

endmodule

bind multiply_shift_hash_collision_check mshc_checker u_mshc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_slot           (out_ch.slot),
  .out_outcome        (out_ch.outcome),
  .out_trial_ok       (out_ch.trial_ok),
  .out_accepted_count (out_ch.accepted_count)
);

/* dv/multiply_shift_hash_collision_check_test.sv */
// Testbench for multiply_shift_hash_collision_check: hash trials, table hits and conflicts.
// Depends on mshc_pkg and the mshc_in_if/mshc_out_if channels; predicts each result in place.
module multiply_shift_hash_collision_check_test;
  import mshc_pkg::*;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned SETTLE       = 40;
  localparam int unsigned TABLE_DEPTH  = 1 << MAX_INDEX_BITS_DEF;
  localparam bit [WORD_W-1:0] ONES     = '1;
  localparam bit [WORD_W-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;
  localparam bit [WORD_W-1:0] GOLDEN   = 64'h9E37_79B9_7F4A_7C15;

  typedef struct {
    bit               start;
    bit [WORD_W-1:0]  mult;
    bit [WIDTH_W-1:0] width;
    bit [WORD_W-1:0]  key;
    bit [WORD_W-1:0]  value;
  } hash_pair_t;

  typedef struct {
    bit [SLOT_W-1:0]  slot;
    outcome_t         outcome;
    bit               ok;
    bit [COUNT_W-1:0] count;
  } slot_verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  mshc_in_if  in_ch ();
  mshc_out_if out_ch ();

  multiply_shift_hash_collision_check i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor state
  bit [STAMP_W-1:0] stamp_mem [TABLE_DEPTH];
  bit [WORD_W-1:0]  value_mem [TABLE_DEPTH];
  bit [STAMP_W-1:0] epoch_now = EPOCH_RESET;
  bit [WORD_W-1:0]  mult_now  = '0;
  bit [WIDTH_W-1:0] width_now = WIDTH_RESET;
  bit               failed_now;
  bit [COUNT_W-1:0] count_now;

  slot_verdict_t verdicts_due [$];
  slot_verdict_t verdict_seen;
  int unsigned   error_count;
  int unsigned   cycle_count;
  int unsigned   stall_left;
  bit            calm;

  function automatic bit [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [WIDTH_W-1:0] clamp_width(input bit [WIDTH_W-1:0] w);
    if (w == 0) return WIDTH_W'(1);
    if (w > MAX_INDEX_BITS_DEF) return WIDTH_W'(MAX_INDEX_BITS_DEF);
    return w;
  endfunction

  function automatic slot_verdict_t judge_pair(input hash_pair_t p);
    slot_verdict_t    v;
    bit [WORD_W-1:0]  product;
    int unsigned      w;
    if (p.start) begin
      epoch_now  = epoch_now + 1;
      mult_now   = p.mult;
      width_now  = clamp_width(p.width);
      failed_now = 1'b0;
      count_now  = '0;
    end
    product = mult_now * p.key;
    w = width_now;
    v.slot = SLOT_W'(product >> (WORD_W - w));
    if (failed_now) begin
      v.outcome = OUT_SKIPPED;
    end else if (stamp_mem[v.slot] != epoch_now) begin
      stamp_mem[v.slot] = epoch_now;
      value_mem[v.slot] = p.value;
      v.outcome = OUT_STORED;
      if (count_now < COUNT_MAX) count_now++;
    end else if (value_mem[v.slot] == p.value) begin
      v.outcome = OUT_MATCHED;
      if (count_now < COUNT_MAX) count_now++;
    end else begin
      v.outcome  = OUT_CONFLICT;
      failed_now = 1'b1;
    end
    v.ok    = !failed_now;
    v.count = count_now;
    return v;
  endfunction

  // receiver: random stall bursts on out_ch.ready
  always @(posedge clk) begin
    if (calm || !rst_n) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("result transfer with no expectation pending, slot %0d", out_ch.slot);
        error_count++;
      end else begin
        verdict_seen = verdicts_due.pop_front();
        if (out_ch.slot !== verdict_seen.slot) begin
          $error("slot: expected %0d, actual %0d", verdict_seen.slot, out_ch.slot);
          error_count++;
        end
        if (out_ch.outcome !== verdict_seen.outcome) begin
          $error("outcome: expected %0d, actual %0d", verdict_seen.outcome, out_ch.outcome);
          error_count++;
        end
        if (out_ch.trial_ok !== verdict_seen.ok) begin
          $error("trial_ok: expected %0d, actual %0d", verdict_seen.ok, out_ch.trial_ok);
          error_count++;
        end
        if (out_ch.accepted_count !== verdict_seen.count) begin
          $error("accepted_count: expected %0d, actual %0d",
                 verdict_seen.count, out_ch.accepted_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // drive one pair and hold it until the transfer
  task automatic push_pair(input bit start, input bit [WORD_W-1:0] mult,
                           input bit [WIDTH_W-1:0] width, input bit [WORD_W-1:0] key,
                           input bit [WORD_W-1:0] value);
    hash_pair_t p;
    p = '{start, mult, width, key, value};
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.start_trial <= start;
    in_ch.multiplier  <= mult;
    in_ch.index_width <= width;
    in_ch.key         <= key;
    in_ch.ref_value   <= value;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    verdicts_due.push_back(judge_pair(p));
  endtask

  task automatic drain_verdicts();
    in_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_trial();
    push_pair(1'b0, GOLDEN, 4'd3, 64'd1, 64'hA5);
    push_pair(1'b0, ONES, 4'd15, ONES, 64'hA5);
    push_pair(1'b0, '0, 4'd0, TOP_BIT, 64'hA5);
  endtask

  task automatic test_corner_items();
    push_pair(1'b1, ONES, 4'd0, '0, '0);
    push_pair(1'b0, '0, 4'd0, ONES, '0);
    push_pair(1'b0, '0, 4'd0, TOP_BIT, ONES);
    push_pair(1'b1, GOLDEN, 4'd15, ONES, ONES);
    push_pair(1'b1, GOLDEN, 4'd13, 64'd1, '0);
    push_pair(1'b1, GOLDEN, 4'd12, TOP_BIT, 64'd42);
    push_pair(1'b0, ONES, 4'd7, rand64(), rand64());
    push_pair(1'b1, GOLDEN, 4'd14, 64'h0123_4567_89AB_CDEF, 64'd42);
    push_pair(1'b1, '0, 4'd4, 64'd5, 64'd7);
    push_pair(1'b0, ONES, 4'd9, 64'd9, 64'd7);
    push_pair(1'b0, GOLDEN, 4'd2, 64'd11, 64'd8);
    push_pair(1'b0, '0, 4'd0, 64'd13, 64'd7);
    push_pair(1'b0, ONES, 4'd15, ONES, ONES);
    push_pair(1'b1, '0, 4'd4, 64'd5, 64'd8);
    push_pair(1'b1, 64'd1, 4'd1, ONES, 64'd3);
    push_pair(1'b1, ONES, 4'd8, '0, '0);
  endtask

  task automatic test_random_trials(input int unsigned n_items);
    bit [WORD_W-1:0]  keys [8];
    bit [WORD_W-1:0]  vals [8];
    bit [WORD_W-1:0]  mult;
    bit [WORD_W-1:0]  key;
    bit [WORD_W-1:0]  value;
    bit [WIDTH_W-1:0] w;
    int unsigned      sent;
    int unsigned      pool_n;
    int unsigned      trial_len;
    int unsigned      pick;
    int unsigned      roll;
    sent = 0;
    while (sent < n_items) begin
      pool_n = $urandom_range(1, 8);
      for (int i = 0; i < pool_n; i++) begin
        keys[i] = rand64();
        vals[i] = $urandom_range(0, 1) ? 64'($urandom_range(0, 1)) : rand64();
      end
      case ($urandom_range(0, 9))
        0:       mult = '0;
        1:       mult = ONES;
        default: mult = rand64();
      endcase
      w = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 5));
      trial_len = $urandom_range(1, 24);
      for (int i = 0; i < trial_len && sent < n_items; i++) begin
        pick  = $urandom_range(0, pool_n - 1);
        key   = keys[pick];
        value = vals[pick];
        roll  = $urandom_range(0, 19);
        if (roll == 0) key = rand64();
        else if (roll == 1) value = rand64();
        if (i == 0) push_pair(1'b1, mult, w, key, value);
        else push_pair(1'b0, rand64(), 4'($urandom), key, value);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.start_trial <= 1'b0;
    in_ch.multiplier  <= '0;
    in_ch.index_width <= '0;
    in_ch.key         <= '0;
    in_ch.ref_value   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_trial();
    test_corner_items();
    drain_verdicts();
    test_random_trials(1250);
    calm = 1'b1;
    test_random_trials(200);
    drain_verdicts();

    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
